@@ sv/lps_pkg.sv @@
// shared constants and types for the preemptive lifo tick scheduler
// no dependencies; imported by the scheduler top level
package lps_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int ID_W        = 16;
    localparam int TIME_W      = 16;
    localparam int ENTRY_W     = ID_W + TIME_W;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    typedef logic [ID_W-1:0]   t_id;
    typedef logic [TIME_W-1:0] t_time;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_count;

    // one stack entry: id in the upper half, remaining service in the lower
    typedef struct packed {
        t_id   id;
        t_time rem;
    } t_entry;

endpackage

@@ sv/lifo_preemptive_scheduler.sv @@
// Preemptive last-come-first-served tick scheduler. Every input word is one
// time tick and yields exactly one result word. An arriving job with nonzero
// service time is pushed on a stack of STACK_DEPTH entries (dropped and
// flagged when full) and the job on top is served for the tick: its id and
// remaining time before the decrement are reported, and it is popped when
// the decremented time reaches zero. An empty stack gives an idle result of zeros.
// Each tick passes S_IDLE, which accepts the word and reads the top entry
// from the stack ram, then S_EXEC, which updates and writes back the entry
// and loads the output register once the output is free. The next word is
// accepted while a result waits to be taken. No clearing pass is needed after reset.
// depends on lps_pkg and lps_ram
module lifo_preemptive_scheduler
    import lps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_action,
    input  logic [ID_W-1:0]   i_arrival_id,
    input  logic [TIME_W-1:0] i_service_time,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_busy_res,
    output logic [ID_W-1:0]   o_running_id,
    output logic [TIME_W-1:0] o_remaining_before,
    output logic              o_job_done,
    output logic              o_arrival_dropped
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state, n_state;
    t_count r_count, n_count;
    logic   r_push, n_push;
    logic   r_busy, n_busy;
    logic   r_drop, n_drop;
    t_id    r_id, n_id;
    t_time  r_svc, n_svc;

    logic   r_out_valid, n_out_valid;
    logic   r_out_busy, n_out_busy;
    t_id    r_out_id, n_out_id;
    t_time  r_out_rem, n_out_rem;
    logic   r_out_done, n_out_done;
    logic   r_out_drop, n_out_drop;

    logic   in_accept;
    logic   arrival;
    logic   full;
    logic   out_free;
    logic   ram_we;
    logic   ram_re;
    t_addr  ram_waddr;
    t_addr  ram_raddr;
    t_entry ram_wdata;
    t_entry ram_rdata;
    t_entry top;
    t_time  rem_dec;
    t_count slot;
    logic   done;

    lps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign arrival    = i_action && (i_service_time != '0);
    assign full       = (r_count == t_count'(STACK_DEPTH));
    assign out_free   = !r_out_valid || !i_out_stall;

    // read the current top while the word is accepted, unless it is replaced
    assign ram_re    = in_accept && !(arrival && !full) && (r_count != '0);
    assign ram_raddr = t_addr'(r_count - t_count'(1));

    // top of stack for this tick: the new arrival or the stored entry
    always_comb begin
        if (r_push) begin
            top.id  = r_id;
            top.rem = r_svc;
            slot    = r_count;
        end else begin
            top  = ram_rdata;
            slot = r_count - t_count'(1);
        end
    end

    assign rem_dec   = top.rem - t_time'(1);
    assign done      = r_busy && (rem_dec == '0);
    assign ram_waddr = t_addr'(slot);
    assign ram_wdata = '{id: top.id, rem: rem_dec};
    assign ram_we    = (r_state == S_EXEC) && out_free && r_busy && !done;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_push      = r_push;
        n_busy      = r_busy;
        n_drop      = r_drop;
        n_id        = r_id;
        n_svc       = r_svc;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_busy  = r_out_busy;
        n_out_id    = r_out_id;
        n_out_rem   = r_out_rem;
        n_out_done  = r_out_done;
        n_out_drop  = r_out_drop;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_push  = arrival && !full;
                    n_drop  = arrival && full;
                    n_busy  = (arrival && !full) || (r_count != '0);
                    n_id    = i_arrival_id;
                    n_svc   = i_service_time;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_busy  = r_busy;
                    n_out_id    = r_busy ? top.id : '0;
                    n_out_rem   = r_busy ? top.rem : '0;
                    n_out_done  = done;
                    n_out_drop  = r_drop;
                    // a push that finishes at once leaves the count alone
                    if (r_push && !done) begin
                        n_count = r_count + t_count'(1);
                    end else if (!r_push && done) begin
                        n_count = r_count - t_count'(1);
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_push     <= n_push;
        r_busy     <= n_busy;
        r_drop     <= n_drop;
        r_id       <= n_id;
        r_svc      <= n_svc;
        r_out_busy <= n_out_busy;
        r_out_id   <= n_out_id;
        r_out_rem  <= n_out_rem;
        r_out_done <= n_out_done;
        r_out_drop <= n_out_drop;
    end

    assign o_out_valid        = r_out_valid;
    assign o_busy_res         = r_out_busy;
    assign o_running_id       = r_out_id;
    assign o_remaining_before = r_out_rem;
    assign o_job_done         = r_out_done;
    assign o_arrival_dropped  = r_out_drop;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_count'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_EXEC))
        else $error("accepted word did not start execution");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_job_done |-> o_busy_res)
        else $error("job done on an idle tick");

    a_drop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_arrival_dropped |-> o_busy_res)
        else $error("dropped arrival with no job running");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_busy_res |-> (o_running_id == '0) && (o_remaining_before == '0))
        else $error("idle result carries nonzero fields");
`endif

endmodule

@@ sv/lps_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies; used as the job stack store
module lps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
